### rtl/assert_macros.svh
// Assertion macros used by the frame encoder back part (wfe_back).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define WFE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define WFE_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/wfe_pkg.sv
// Shared types and constants of the WebSocket frame encoder.
`default_nettype none

package wfe_pkg;

	localparam int unsigned MSG_W  = 32;
	localparam int unsigned FLEN_W = 21;
	localparam int unsigned KEY_W  = 32;

	// Queue between the front and the back.
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);

	localparam logic [FLEN_W-1:0] LIMIT_RESET = FLEN_W'(16384);

	// Header codes.
	localparam logic [3:0]        OP_TEXT    = 4'h1;
	localparam logic [3:0]        OP_CONT    = 4'h0;
	localparam logic [FLEN_W-1:0] LEN7_MAX   = FLEN_W'(125);
	localparam logic [FLEN_W-1:0] LEN16_MAX  = FLEN_W'(16'hffff);
	localparam logic [6:0]        LEN_CODE16 = 7'd126;
	localparam logic [6:0]        LEN_CODE64 = 7'd127;

	// Length field form of a frame header.
	typedef enum logic [1:0] {
		LEN_SHORT,
		LEN_EXT16,
		LEN_EXT64
	} len_cls_t;

	// One classified item handed from the front to the back.
	typedef struct packed {
		logic              frame_start;
		logic              fin;
		logic              opcode_text;
		len_cls_t          len_cls;
		logic [FLEN_W-1:0] flen;
		logic [KEY_W-1:0]  key;
		logic [7:0]        masked;
		logic              frame_end;
		logic              message_end;
	} cmd_t;

endpackage

`default_nettype wire

### rtl/websocket_frame_encoder.sv
// Top level of the masked WebSocket client frame encoder.
`default_nettype none

// Takes one payload byte per transfer and emits the masked wire stream, one byte per
// cycle while m_axis_tready is high. An input byte is accepted every cycle while the
// four-entry command queue has room; a byte that opens a frame is preceded by 6, 8 or
// 14 header bytes (7-bit, 16-bit or 64-bit length form), so the output register sets the
// sustained rate. The user must write the frame limit register through cfg_we/cfg_wdata
// only between messages; the block itself does not enforce this.
module websocket_frame_encoder (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [wfe_pkg::FLEN_W-1:0]  cfg_wdata,     // frame_limit
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [71:0]                 s_axis_tdata,  // payload_byte, message_length, mask_key
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	output logic [7:0]                       m_axis_tdata,  // out_byte
	output logic [2:0]                       m_axis_tuser,  // is_header, message_end, last
	output logic                             m_axis_tlast   // frame_end
);

	logic          q_full;
	logic          q_push;
	wfe_pkg::cmd_t q_push_cmd;
	logic          q_pop;
	wfe_pkg::cmd_t q_head_cmd;
	logic          q_not_empty;

	// Classification and masking.
	wfe_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_cmd         (q_push_cmd)
	);

	// Decoupling queue.
	wfe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.head_cmd  (q_head_cmd),
		.not_empty (q_not_empty)
	);

	// Header sequencing and output register.
	wfe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_not_empty),
		.q_cmd         (q_head_cmd),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire

### rtl/wfe_front.sv
// Front part: accepts payload bytes, tracks message and frame state, masks data.
`default_nettype none

module wfe_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [wfe_pkg::FLEN_W-1:0]  cfg_wdata,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [71:0]                 s_axis_tdata,
	input  wire logic                        q_full,
	output logic                             q_push,
	output wfe_pkg::cmd_t                    q_cmd
);

	logic [wfe_pkg::FLEN_W-1:0] frame_limit_q;
	logic [wfe_pkg::MSG_W-1:0]  message_left_q;
	logic [wfe_pkg::FLEN_W-1:0] frame_left_q;
	logic                       first_frame_q;
	logic [wfe_pkg::KEY_W-1:0]  frame_key_q;
	logic [1:0]                 key_position_q;

	logic [7:0]                 data_in;
	logic [wfe_pkg::MSG_W-1:0]  len_in;
	logic [wfe_pkg::KEY_W-1:0]  key_in;
	logic                       idle;
	logic                       take;
	logic [wfe_pkg::MSG_W-1:0]  cur_msg;
	logic [wfe_pkg::FLEN_W-1:0] lim;
	logic                       fits;
	logic                       frame_start;
	logic [wfe_pkg::FLEN_W-1:0] flen;
	logic [wfe_pkg::FLEN_W-1:0] cur_frame;
	logic [wfe_pkg::KEY_W-1:0]  key;
	logic [1:0]                 pos;
	logic                       fend;
	logic                       mend;

	// Unpack the input transfer.
	assign data_in = s_axis_tdata[7:0];
	assign len_in  = s_axis_tdata[39:8];
	assign key_in  = s_axis_tdata[71:40];

	assign s_axis_tready = !q_full;

	// A message starts when nothing is left; a zero length start is dropped.
	assign idle = (message_left_q == '0);
	assign take = s_axis_tvalid && !q_full && !(idle && (len_in == '0));

	// Frame sizing for a frame that starts with this byte.
	assign cur_msg     = idle ? len_in : message_left_q;
	assign lim         = (frame_limit_q == '0) ? wfe_pkg::FLEN_W'(1) : frame_limit_q;
	assign fits        = (cur_msg <= {{(wfe_pkg::MSG_W - wfe_pkg::FLEN_W){1'b0}}, lim});
	assign frame_start = (frame_left_q == '0);
	assign flen        = fits ? cur_msg[wfe_pkg::FLEN_W-1:0] : lim;
	assign cur_frame   = frame_start ? flen : frame_left_q;
	assign key         = frame_start ? key_in : frame_key_q;
	assign pos         = frame_start ? 2'd0 : key_position_q;
	assign fend        = (cur_frame == wfe_pkg::FLEN_W'(1));
	assign mend        = (cur_msg == wfe_pkg::MSG_W'(1));

	// Build the command for the back part.
	always_comb begin
		q_cmd.frame_start = frame_start;
		q_cmd.fin         = fits;
		q_cmd.opcode_text = first_frame_q;
		if (flen > wfe_pkg::LEN16_MAX) begin
			q_cmd.len_cls = wfe_pkg::LEN_EXT64;
		end else if (flen > wfe_pkg::LEN7_MAX) begin
			q_cmd.len_cls = wfe_pkg::LEN_EXT16;
		end else begin
			q_cmd.len_cls = wfe_pkg::LEN_SHORT;
		end
		q_cmd.flen        = flen;
		q_cmd.key         = key;
		q_cmd.masked      = data_in ^ key[{pos, 3'b000} +: 8];
		q_cmd.frame_end   = fend;
		q_cmd.message_end = mend;
	end

	assign q_push = take;

	// Configuration register and message state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_limit_q  <= wfe_pkg::LIMIT_RESET;
			message_left_q <= '0;
			frame_left_q   <= '0;
			first_frame_q  <= 1'b1;
			frame_key_q    <= '0;
			key_position_q <= '0;
		end else begin
			if (cfg_we) begin
				frame_limit_q <= cfg_wdata;
			end
			if (take) begin
				message_left_q <= cur_msg - wfe_pkg::MSG_W'(1);
				frame_left_q   <= cur_frame - wfe_pkg::FLEN_W'(1);
				frame_key_q    <= key;
				key_position_q <= pos + 2'd1;
				if (mend) begin
					first_frame_q <= 1'b1;
				end else if (frame_start) begin
					first_frame_q <= 1'b0;
				end
			end
		end
	end

endmodule

`default_nettype wire

### rtl/wfe_queue.sv
// Short command queue between the front and the back.
`default_nettype none

module wfe_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire wfe_pkg::cmd_t  push_cmd,
	output logic                full,
	input  wire logic           pop,
	output wfe_pkg::cmd_t       head_cmd,
	output logic                not_empty
);

	wfe_pkg::cmd_t               entry_q [wfe_pkg::QDEPTH];
	logic [wfe_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [wfe_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [wfe_pkg::QPTR_W:0]    count_q;

	assign full      = (count_q == (wfe_pkg::QPTR_W + 1)'(wfe_pkg::QDEPTH));
	assign not_empty = (count_q != '0);
	assign head_cmd  = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/wfe_back.sv
// Back part: walks the header bytes of a frame and emits the wire bytes.
`default_nettype none
`include "assert_macros.svh"

module wfe_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  wire wfe_pkg::cmd_t  q_cmd,
	output logic                q_pop,
	output logic                m_axis_tvalid,
	input  wire logic           m_axis_tready,
	output logic [7:0]          m_axis_tdata,
	output logic [2:0]          m_axis_tuser,
	output logic                m_axis_tlast
);

	logic [3:0]  idx_q;
	logic        m_tvalid_q;
	logic [7:0]  m_tdata_q;
	logic [2:0]  m_tuser_q;
	logic        m_tlast_q;

	logic [3:0]  ext_n;
	logic [3:0]  hdr_n;
	logic        at_payload;
	logic        adv;
	logic [3:0]  len_sel;
	logic [3:0]  key_sel;
	logic [63:0] len64;
	logic [6:0]  len_code;
	logic [7:0]  byte_out;

	// Header size for this command: two fixed bytes, extended length, key.
	always_comb begin
		unique case (q_cmd.len_cls)
			wfe_pkg::LEN_EXT16: begin
				ext_n    = 4'd2;
				len_code = wfe_pkg::LEN_CODE16;
			end
			wfe_pkg::LEN_EXT64: begin
				ext_n    = 4'd8;
				len_code = wfe_pkg::LEN_CODE64;
			end
			default: begin
				ext_n    = 4'd0;
				len_code = q_cmd.flen[6:0];
			end
		endcase
	end

	assign hdr_n      = q_cmd.frame_start ? (ext_n + 4'd6) : 4'd0;
	assign at_payload = (idx_q == hdr_n);
	assign len64      = {{(64 - wfe_pkg::FLEN_W){1'b0}}, q_cmd.flen};
	assign len_sel    = ext_n + 4'd1 - idx_q;
	assign key_sel    = idx_q - 4'd2 - ext_n;

	// Select the byte at the current position of the frame.
	always_comb begin
		if (at_payload) begin
			byte_out = q_cmd.masked;
		end else if (idx_q == 4'd0) begin
			byte_out = {q_cmd.fin, 3'b000,
				q_cmd.opcode_text ? wfe_pkg::OP_TEXT : wfe_pkg::OP_CONT};
		end else if (idx_q == 4'd1) begin
			byte_out = {1'b1, len_code};
		end else if (idx_q < (ext_n + 4'd2)) begin
			byte_out = len64[{len_sel[2:0], 3'b000} +: 8];
		end else begin
			byte_out = q_cmd.key[{key_sel[1:0], 3'b000} +: 8];
		end
	end

	// The output register advances when empty or when its transfer completes.
	assign adv   = !m_tvalid_q || m_axis_tready;
	assign q_pop = adv && q_valid && at_payload;

	// Output valid and header position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			idx_q      <= '0;
		end else if (adv) begin
			m_tvalid_q <= q_valid;
			if (q_valid) begin
				idx_q <= at_payload ? 4'd0 : (idx_q + 4'd1);
			end
		end
	end

	// Output payload; tuser is {last, message_end, is_header}.
	always_ff @(posedge clk) begin
		if (adv && q_valid) begin
			m_tdata_q <= byte_out;
			m_tuser_q <= {at_payload, at_payload && q_cmd.message_end, !at_payload};
			m_tlast_q <= at_payload && q_cmd.frame_end;
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;
	assign m_axis_tlast  = m_tlast_q;

	// A queue entry leaves only with its payload byte, then the header restarts.
	`WFE_ASSERT(a_pop_restarts, clk, arst_n, q_pop |=> (idx_q == 4'd0), "header index not reset after pop")
	// Header position never runs past the longest header.
	`WFE_NEVER(a_idx_range, clk, arst_n, idx_q > 4'd14, "header index out of range")
	// The end of a message always closes its frame.
	`WFE_NEVER(a_mend_fend, clk, arst_n, m_tvalid_q && m_tuser_q[1] && !m_tlast_q, "message end without frame end")
	// Header bytes carry no end marks and never close an input item.
	`WFE_NEVER(a_hdr_flags, clk, arst_n, m_tvalid_q && m_tuser_q[0] && (m_tlast_q || m_tuser_q[2]), "end marks on a header byte")

endmodule

`default_nettype wire
